// ----- rtl/ffha_pkg.sv -----
// Shared constants and types for the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	// Default pool geometry.
	localparam int POOL_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 24;

	// A free block is split only when its surplus exceeds a header plus this slack.
	localparam int SPLIT_SLACK = 16;

	// Field widths of the request and result items.
	localparam int REQ_W   = 16;
	localparam int OFF_W   = 12;
	localparam int TOTAL_W = 13;
	localparam int LIVE_W  = 8;

	// Request kinds carried on the input tuser.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes carried on the output tuser.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_ZERO   = 3'd1,
		ST_NOFIT  = 3'd2,
		ST_BADOFF = 3'd3,
		ST_DOUBLE = 3'd4
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator with a block walker over a header memory.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: op; tdata: req_bytes, free_offset
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: payload_offset,
//                                                     allocated_bytes, free_bytes, live_count
//
// The pool is kept as a chain of blocks that tile it with no gaps. The header memory
// holds one entry (free flag and payload size) at the address of each block start,
// so the next block is found by adding the header size and the payload size to the
// current start. One walker steps through the chain at one header read per cycle.
//
// Walks: an allocate visits each block up to and including the first fit, with one
// more step when the block is split. A free visits each block up to the target, then
// makes a full coalescing walk over every block. With the default pool that is at
// most about 146 blocks per walk. The chained read address (header memory latency
// plus one add) sets the step rate. A zero-size allocate skips the walk.
//
// Reset needs no clearing pass: only block starts are ever read, every start except
// the first is written when it is created, and the first entry reads as the whole
// free pool until it is written. The input is taken only while the walker is idle.
// A finished result waits in the output register while the next request is taken;
// a new result waits in its last state until the output register is free.

module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [15:0] req_bytes, [27:16] free_offset
	input  wire logic        s_axis_tuser,   // [0] op

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [11:0] payload_offset, [24:12] allocated_bytes,
	                                         // [37:25] free_bytes, [45:38] live_count
	output logic [2:0]       m_axis_tuser    // [2:0] status
);

	// Block starts are multiples of this granule, which sets the memory index.
	localparam int GRAN  = (HEADER_BYTES % 4 == 0) ? 4 : ((HEADER_BYTES % 2 == 0) ? 2 : 1);
	localparam int GSH   = (GRAN == 4) ? 2 : ((GRAN == 2) ? 1 : 0);
	localparam int DEPTH = (POOL_BYTES + GRAN - 1) / GRAN;
	localparam int IW    = $clog2(DEPTH);
	localparam int AW    = $clog2(POOL_BYTES + 1);
	localparam int SZW   = REQ_W + 1;
	localparam int WW    = ((AW > SZW) ? AW : SZW) + 2;

	localparam logic [AW:0]   HDR_A  = (AW + 1)'(HEADER_BYTES);
	localparam logic [AW:0]   POOL_A = (AW + 1)'(POOL_BYTES);
	localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
	localparam logic [WW-1:0] SLK_W  = WW'(SPLIT_SLACK);

	typedef struct packed {
		logic          free;
		logic [AW-1:0] size;
	} entry_t;

	localparam entry_t RESET_ENT = '{free: 1'b1, size: AW'(POOL_BYTES - HEADER_BYTES)};

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_SPLIT,
		S_MSTART,
		S_MWALK,
		S_RESULT
	} state_t;

	function automatic logic [IW-1:0] idx_of(input logic [AW-1:0] a);
		idx_of = IW'(a >> GSH);
	endfunction

	state_t                state_q;
	logic                  op_q;
	logic [SZW-1:0]        sz_q;
	logic [OFF_W-1:0]      off_q;
	logic [AW-1:0]         cur_q;
	logic [AW-1:0]         rem_q;
	logic [AW-1:0]         split_addr_q;
	logic                  run_q;
	logic                  dirty_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         run_size_q;
	status_t               status_q;
	logic [OFF_W-1:0]      pay_q;
	logic [TOTAL_W-1:0]    alloc_q;
	logic [TOTAL_W-1:0]    free_q;
	logic [LIVE_W-1:0]     live_q;
	logic                  e0_valid_q;
	logic                  m_valid_q;
	logic [47:0]           m_data_q;
	logic [2:0]            m_user_q;

	// Header memory and its registered read port.
	entry_t                mem [DEPTH];
	entry_t                rd_q;
	logic                  rd_dflt_q;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  we;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;
	logic [IW-1:0]         rd_idx;
	logic [IW-1:0]         wr_idx;

	entry_t                ent;
	logic [AW:0]           nxt;
	logic                  at_end;
	logic [WW-1:0]         ent_size_w;
	logic [WW-1:0]         sz_w;
	logic                  fits;
	logic                  split;
	logic                  match;
	logic [SZW-1:0]        in_sz;
	logic                  in_zero;
	logic                  run_nx;
	logic                  dirty_nx;
	logic [AW-1:0]         head_nx;
	logic [AW-1:0]         run_size_nx;
	logic [WW-1:0]         bsz_w;
	logic                  out_free;

	// Entry of the block at cur_q; the first entry reads as the whole pool until written.
	assign ent        = rd_dflt_q ? RESET_ENT : rd_q;
	assign nxt        = {1'b0, cur_q} + HDR_A + {1'b0, ent.size};
	assign at_end     = (nxt >= POOL_A);
	assign ent_size_w = WW'(ent.size);
	assign sz_w       = WW'(sz_q);
	assign fits       = ent.free && (ent_size_w >= sz_w);
	assign split      = ent_size_w > (sz_w + HDR_W + SLK_W);
	assign match      = (WW'(cur_q) + HDR_W) == WW'(off_q);
	assign bsz_w      = split ? sz_w : ent_size_w;
	assign in_sz      = ({1'b0, s_axis_tdata[REQ_W-1:0]} + SZW'(3)) & ~SZW'(3);
	assign in_zero    = (s_axis_tdata[REQ_W-1:0] == '0);
	assign out_free   = !m_valid_q || m_axis_tready;
	assign rd_idx     = idx_of(rd_addr);
	assign wr_idx     = idx_of(wr_addr);

	// Run tracking for the coalescing walk.
	always_comb begin
		run_nx      = run_q;
		dirty_nx    = dirty_q;
		head_nx     = head_q;
		run_size_nx = run_size_q;
		if (ent.free) begin
			if (run_q) begin
				run_size_nx = AW'({1'b0, run_size_q} + HDR_A + {1'b0, ent.size});
				dirty_nx    = 1'b1;
			end else begin
				run_nx      = 1'b1;
				head_nx     = cur_q;
				run_size_nx = ent.size;
				dirty_nx    = 1'b0;
			end
		end else begin
			run_nx   = 1'b0;
			dirty_nx = 1'b0;
		end
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = cur_q;
		wr_data = ent;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && !(s_axis_tuser == OP_ALLOC && in_zero)) begin
					rd_en = 1'b1;
				end
			end
			S_WALK: begin
				if (op_q == OP_ALLOC) begin
					if (fits) begin
						we           = 1'b1;
						wr_data.free = 1'b0;
						wr_data.size = split ? AW'(sz_q) : ent.size;
					end else if (!at_end) begin
						rd_en   = 1'b1;
						rd_addr = AW'(nxt);
					end
				end else begin
					if (match) begin
						if (!ent.free) begin
							we           = 1'b1;
							wr_data.free = 1'b1;
						end
					end else if (!at_end) begin
						rd_en   = 1'b1;
						rd_addr = AW'(nxt);
					end
				end
			end
			S_SPLIT: begin
				we      = 1'b1;
				wr_addr = split_addr_q;
				wr_data = '{free: 1'b1, size: rem_q};
			end
			S_MSTART: begin
				rd_en = 1'b1;
			end
			S_MWALK: begin
				if (!ent.free && run_q && dirty_q) begin
					// A run of free blocks ended: its head takes the whole run.
					we      = 1'b1;
					wr_addr = head_q;
					wr_data = '{free: 1'b1, size: run_size_q};
				end else if (ent.free && at_end && dirty_nx) begin
					we      = 1'b1;
					wr_addr = head_nx;
					wr_data = '{free: 1'b1, size: run_size_nx};
				end
				if (!at_end) begin
					rd_en   = 1'b1;
					rd_addr = AW'(nxt);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_idx];
			rd_dflt_q <= (rd_idx == '0) && !e0_valid_q;
		end
	end

	// Sequencer, statistics and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ALLOC;
			sz_q         <= '0;
			off_q        <= '0;
			cur_q        <= '0;
			rem_q        <= '0;
			split_addr_q <= '0;
			run_q        <= 1'b0;
			dirty_q      <= 1'b0;
			head_q       <= '0;
			run_size_q   <= '0;
			status_q     <= ST_OK;
			pay_q        <= '0;
			alloc_q      <= '0;
			free_q       <= TOTAL_W'(POOL_BYTES - HEADER_BYTES);
			live_q       <= '0;
			e0_valid_q   <= 1'b0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			m_user_q     <= '0;
		end else begin
			// A new result loads when the register is empty or draining this cycle.
			if (state_q == S_RESULT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (we && wr_idx == '0) begin
				e0_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q  <= s_axis_tuser;
						sz_q  <= in_sz;
						off_q <= s_axis_tdata[REQ_W +: OFF_W];
						cur_q <= '0;
						pay_q <= '0;
						if (s_axis_tuser == OP_ALLOC && in_zero) begin
							status_q <= ST_ZERO;
							state_q  <= S_RESULT;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (op_q == OP_ALLOC) begin
						if (fits) begin
							alloc_q      <= alloc_q + TOTAL_W'(bsz_w);
							free_q       <= free_q - TOTAL_W'(bsz_w);
							live_q       <= live_q + LIVE_W'(1);
							pay_q        <= OFF_W'(WW'(cur_q) + HDR_W);
							status_q     <= ST_OK;
							rem_q        <= ent.size - AW'(sz_q) - AW'(HEADER_BYTES);
							split_addr_q <= AW'({1'b0, cur_q} + HDR_A + (AW + 1)'(sz_q));
							state_q      <= split ? S_SPLIT : S_RESULT;
						end else if (at_end) begin
							status_q <= ST_NOFIT;
							state_q  <= S_RESULT;
						end else begin
							cur_q <= AW'(nxt);
						end
					end else begin
						if (match) begin
							if (ent.free) begin
								status_q <= ST_DOUBLE;
								state_q  <= S_RESULT;
							end else begin
								alloc_q  <= alloc_q - TOTAL_W'(ent_size_w);
								free_q   <= free_q + TOTAL_W'(ent_size_w);
								live_q   <= live_q - LIVE_W'(1);
								status_q <= ST_OK;
								state_q  <= S_MSTART;
							end
						end else if (at_end) begin
							status_q <= ST_BADOFF;
							state_q  <= S_RESULT;
						end else begin
							cur_q <= AW'(nxt);
						end
					end
				end
				S_SPLIT: begin
					state_q <= S_RESULT;
				end
				S_MSTART: begin
					cur_q   <= '0;
					run_q   <= 1'b0;
					dirty_q <= 1'b0;
					state_q <= S_MWALK;
				end
				S_MWALK: begin
					run_q      <= run_nx;
					dirty_q    <= dirty_nx;
					head_q     <= head_nx;
					run_size_q <= run_size_nx;
					if (at_end) begin
						state_q <= S_RESULT;
					end else begin
						cur_q <= AW'(nxt);
					end
				end
				S_RESULT: begin
					if (out_free) begin
						m_user_q <= status_q;
						m_data_q <= {2'b00, live_q, free_q, alloc_q, pay_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// The walker never steps past the end of the pool.
	a_walk_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_MWALK) |-> ({1'b0, cur_q} < POOL_A))
		else $error("walker address beyond pool");

	// A header write never lands on the entry being read in the same cycle.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && we) |-> (rd_idx != wr_idx))
		else $error("header memory read and write collide");

	// Every result other than a good allocate carries a zero payload offset.
	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[11:0] == '0))
		else $error("failed request reports a payload offset");

	// A result is loaded only into an empty or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
